@@ rtl/core/bcf_pkg.sv @@
// Package for the Bezier curve flattener: constants, types and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package bcf_pkg;
    localparam int unsigned MaxSegments = 64;
    localparam int unsigned MinSegments = 20;
    localparam int unsigned SetW        = 7;
    localparam int unsigned CoordW      = 32;
    localparam int unsigned WeightW     = 17;  // 0..65536

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_EVAL,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the segment
        logic wt_start;   // start weight division for current index
        logic eval_start; // start term evaluation
        logic out_load;   // move the finished point to the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic wt_done;
        logic eval_done;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/core/bcf_ctrl.sv @@
// Controller for the Bezier curve flattener: sequences index, weight
// division, term evaluation and output. Depends on bcf_pkg.
`default_nettype none
module bcf_ctrl #(
    parameter int unsigned MAX_SEGMENTS = bcf_pkg::MaxSegments
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_out_free,
    input  wire logic [bcf_pkg::SetW-1:0] i_setting,
    input  wire bcf_pkg::t_sts         i_sts,
    output bcf_pkg::t_cmd              o_cmd,
    output logic [bcf_pkg::SetW-1:0]   o_idx,
    output logic [bcf_pkg::SetW-1:0]   o_n,
    output logic                       o_last
);
    import bcf_pkg::*;

    t_state r_state, n_state;
    logic [SetW-1:0] r_idx, n_idx;
    logic [SetW-1:0] r_n, n_n;
    logic [SetW-1:0] w_n_clamp;

    // clamp requested segment count
    always_comb begin
        if (i_setting < SetW'(MinSegments)) begin
            w_n_clamp = SetW'(MinSegments);
        end else if (i_setting > SetW'(MAX_SEGMENTS)) begin
            w_n_clamp = SetW'(MAX_SEGMENTS);
        end else begin
            w_n_clamp = i_setting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_n     <= SetW'(MinSegments);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_n        = r_n;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    n_n            = w_n_clamp;
                    n_idx          = SetW'(1);
                    n_state        = ST_WEIGHT;
                end
            end
            ST_WEIGHT: begin
                if (i_sts.wt_done) begin
                    o_cmd.eval_start = 1'b1;
                    n_state          = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.eval_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_idx == r_n) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + SetW'(1);
                        n_state = ST_WEIGHT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.wt_start = (r_state == ST_IDLE && i_in_valid) ||
                         (r_state == ST_OUT && i_out_free && r_idx != r_n);
    end

    assign o_idx  = (r_state == ST_IDLE) ? SetW'(1) : n_idx;
    assign o_n    = (r_state == ST_IDLE) ? w_n_clamp : r_n;
    assign o_last = (r_idx == r_n);

    ap_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> (r_idx != '0 && r_idx <= r_n))
        else $error("index out of range");
    ap_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n >= SetW'(MinSegments) && r_n <= SetW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    ap_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE)
        else $error("load outside idle");
endmodule
`default_nettype wire

@@ rtl/core/bcf_dpath.sv @@
// Datapath for the Bezier curve flattener: weight divider, shared
// multiplier sequencing the Bernstein terms, summing and saturation.
// Depends on bcf_pkg.
`default_nettype none
module bcf_dpath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bcf_pkg::t_cmd             i_cmd,
    output bcf_pkg::t_sts                  o_sts,
    input  wire logic [bcf_pkg::SetW-1:0]  i_idx,
    input  wire logic [bcf_pkg::SetW-1:0]  i_n,
    input  wire logic                      i_cmd_cubic,
    input  wire logic [8*bcf_pkg::CoordW-1:0] i_pts, // sx,sy,c1x,c1y,c2x,c2y,ex,ey
    output logic signed [bcf_pkg::CoordW-1:0] o_px,
    output logic signed [bcf_pkg::CoordW-1:0] o_py
);
    import bcf_pkg::*;

    localparam int unsigned AccW  = 38;
    localparam int unsigned ProdW = AccW + WeightW + 1;

    // captured segment
    logic signed [CoordW-1:0] r_pt [8];
    logic                     r_cubic;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 8; k++) begin
                r_pt[k] <= i_pts[k*CoordW +: CoordW];
            end
            r_cubic <= i_cmd_cubic;
        end
    end

    // restoring divider: a = floor(idx*65536/n), one quotient bit a cycle
    localparam int unsigned DivBits = WeightW;
    logic [SetW+DivBits-1:0] r_dnum;
    logic [SetW:0]           r_rem;
    logic [WeightW-1:0]      r_quo;
    logic [SetW-1:0]         r_dden;
    logic [4:0]              r_dcnt;
    logic                    r_dbusy;
    logic                    r_wdone;
    logic [SetW:0]           w_rsh;

    assign w_rsh = {r_rem[SetW-1:0], r_dnum[SetW+DivBits-1]};

    // done flag rises once the last quotient bit has landed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
            r_wdone <= 1'b0;
        end else begin
            r_wdone <= r_dbusy && (r_dcnt == 5'd1);
            if (i_cmd.wt_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= 5'(SetW + DivBits);
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 5'd1;
                if (r_dcnt == 5'd1) begin
                    r_dbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wt_start) begin
            r_dnum <= {i_idx, {(DivBits){1'b0}}} >> 1;
            r_dden <= i_n;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_dbusy) begin
            r_dnum <= r_dnum << 1;
            if (w_rsh >= {1'b0, r_dden}) begin
                r_rem <= w_rsh - {1'b0, r_dden};
                r_quo <= {r_quo[WeightW-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[WeightW-2:0], 1'b0};
            end
        end
    end

    assign o_sts.wt_done = r_wdone;

    // evaluation sequencer: term t, step s on axis ax
    logic [WeightW-1:0] w_a, w_b;
    assign w_a = r_quo;
    assign w_b = WeightW'(17'd65536) - r_quo;

    logic signed [AccW-1:0] r_sum;
    logic signed [CoordW-1:0] r_resx;
    logic               r_mvalid;
    logic signed [ProdW-1:0] r_prod;
    logic [1:0]         r_pterm;
    logic [1:0]         r_pstep;
    logic               r_pax;
    logic               r_edone;

    logic [1:0] w_nterm, w_nsteps;
    assign w_nterm  = r_cubic ? 2'd3 : 2'd2;
    assign w_nsteps = r_cubic ? 2'd3 : 2'd2;

    // weight for term t at step s (count of a factors = t)
    function automatic logic use_a(input logic [1:0] t, input logic [1:0] s);
        use_a = (s < t);
    endfunction

    // point index for term t on axis ax
    function automatic logic [2:0] pidx(input logic cub, input logic [1:0] t,
                                        input logic ax);
        logic [2:0] base;
        if (!cub && t == 2'd2) begin
            base = 3'd3;
        end else begin
            base = {1'b0, t};
        end
        pidx = {base[1:0], ax};
    endfunction

    logic signed [AccW-1:0]   w_floor;
    logic signed [AccW+1:0]   w_scaled;
    logic signed [AccW-1:0]   w_sum_n;
    logic signed [CoordW-1:0] w_sat;
    logic                     w_chain_end;

    assign w_floor     = AccW'(r_prod >>> 16);
    assign w_chain_end = (r_pstep == w_nsteps - 2'd1);

    always_comb begin
        if ((r_cubic && (r_pterm == 2'd1 || r_pterm == 2'd2)) ||
            (!r_cubic && r_pterm == 2'd1)) begin
            w_scaled = r_cubic ? (AccW+2)'(w_floor) * 3 : (AccW+2)'(w_floor) * 2;
        end else begin
            w_scaled = (AccW+2)'(w_floor);
        end
        w_sum_n = r_sum + AccW'(w_scaled);
        if (w_sum_n > AccW'(64'sh7FFFFFFF)) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum_n < -AccW'(64'sh80000000)) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum_n[CoordW-1:0];
        end
    end

    // multiply stage: issue one product per cycle when the previous lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
            r_edone  <= 1'b0;
        end else begin
            r_edone <= 1'b0;
            if (i_cmd.eval_start) begin
                r_mvalid <= 1'b1;
            end else if (r_mvalid) begin
                r_mvalid <= !(w_chain_end && r_pterm == w_nterm && r_pax);
                if (w_chain_end && r_pterm == w_nterm && r_pax) begin
                    r_edone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_start) begin
            r_sum   <= '0;
            r_pterm <= '0;
            r_pstep <= '0;
            r_pax   <= 1'b0;
            r_prod  <= ProdW'(AccW'(r_pt[pidx(r_cubic, 2'd0, 1'b0)])) *
                       $signed({1'b0, w_b});
        end else if (r_mvalid) begin
            logic signed [AccW-1:0] v;
            logic [1:0] t, s;
            logic       ax;
            v  = w_floor;
            t  = r_pterm;
            s  = r_pstep + 2'd1;
            ax = r_pax;
            if (w_chain_end) begin
                s = '0;
                if (r_pterm == w_nterm) begin
                    t  = '0;
                    ax = 1'b1;
                    r_resx <= w_sat;
                    r_sum  <= '0;
                end else begin
                    t = r_pterm + 2'd1;
                    r_sum <= w_sum_n;
                end
                v = AccW'(r_pt[pidx(r_cubic, t, ax)]);
            end
            r_pterm <= t;
            r_pstep <= s;
            r_pax   <= ax;
            r_prod  <= ProdW'(v) * $signed({1'b0, use_a(t, s) ? w_a : w_b});
            if (w_chain_end && r_pterm == w_nterm && r_pax) begin
                o_px <= r_resx;
                o_py <= w_sat;
            end
        end
    end

    assign o_sts.eval_done = r_edone;

    ap_div_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dbusy |-> !r_mvalid) else $error("weight changed during evaluation");
    ap_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edone |=> !r_edone) else $error("repeated evaluation done");
    ap_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid |-> r_quo <= WeightW'(17'd65536)) else $error("weight above one");
endmodule
`default_nettype wire

@@ rtl/core/bezier_curve_flattener.sv @@
// Bezier curve flattener: n points per curve at a = idx/n, Q16.16.
// Per point: weight division, then 2*4*3 (cubic) or 2*3*2 (quadratic) products
// through one 38x18 multiplier, then the output register; one curve at a time.
// Synchronous active-low reset clears control; segment_setting resets to 0.
`default_nettype none
module bezier_curve_flattener #(
    parameter int unsigned MAX_SEGMENTS = bcf_pkg::MaxSegments
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [6:0]   i_cfg_data,     // segment_setting
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [255:0] s_axis_tdata,   // start_x,start_y,ctrl1_x,ctrl1_y,
                                              // ctrl2_x,ctrl2_y,end_x,end_y
    input  wire logic         s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // point_x, point_y
    output logic              m_axis_tlast    // last_point
);
    import bcf_pkg::*;

    logic [SetW-1:0] r_setting;
    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [SetW-1:0] w_idx, w_n;
    logic            w_last, w_out_free;
    logic signed [CoordW-1:0] w_px, w_py;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= '0;
        end else if (i_cfg_valid) begin
            r_setting <= i_cfg_data;
        end
    end

    bcf_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .i_setting  (r_setting),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .o_n        (w_n),
        .o_last     (w_last)
    );

    bcf_dpath u_dpath (
        .i_clk, .i_rst_n,
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_idx       (w_idx),
        .i_n         (w_n),
        .i_cmd_cubic (s_axis_tuser),
        .i_pts       (s_axis_tdata),
        .o_px        (w_px),
        .o_py        (w_py)
    );

    // output register
    logic r_ovalid;
    assign w_out_free = !r_ovalid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            m_axis_tdata <= {w_py, w_px};
            m_axis_tlast <= w_last;
        end
    end
    assign m_axis_tvalid = r_ovalid;
endmodule
`default_nettype wire
